// File: src/gzhne_pkg.sv
// Shared types and constants for the gzip header name extractor.
// Holds the result record and the status codes; no dependencies.
package gzhne_pkg;

  localparam logic [7:0] MagicByte0 = 8'h1F;
  localparam logic [7:0] MagicByte1 = 8'h8B;
  localparam logic [7:0] MethodDeflate = 8'h08;
  localparam int unsigned FlagExtraBit = 2;
  localparam int unsigned FlagNameBit = 3;
  localparam logic [3:0] FixedLen = 4'd10;

  localparam logic [2:0] StatusNameDone = 3'd0;
  localparam logic [2:0] StatusNoName = 3'd1;
  localparam logic [2:0] StatusBadMagic = 3'd2;
  localparam logic [2:0] StatusHdrTrunc = 3'd3;
  localparam logic [2:0] StatusNameTrunc = 3'd4;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

// File: src/gzhne_front.sv
// Front end: accepts file bytes, walks the gzip header and classifies each byte.
// Produces at most one result request per byte; depends on gzhne_pkg.
module gzhne_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_file_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output gzhne_pkg::result_t push_data_o
);
  import gzhne_pkg::*;

  localparam logic [2:0] PhFixed = 3'd0;
  localparam logic [2:0] PhXlo = 3'd1;
  localparam logic [2:0] PhXhi = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhName = 3'd4;
  localparam logic [2:0] PhWait = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  header_count_q, header_count_d;
  logic        extra_flag_q, extra_flag_d;
  logic        name_flag_q, name_flag_d;
  logic [7:0]  extra_low_q, extra_low_d;
  logic [15:0] skip_q, skip_d;

  logic [2:0]  next_phase;
  logic        done;
  logic        name_valid;
  logic [2:0]  status;
  logic        ef, nf;
  logic        magic_bad;
  logic        accept;
  logic [15:0] extra_len;

  assign in_ready_o = push_ready_i;
  assign accept = in_valid_i & push_ready_i;
  assign extra_len = {data_byte_i, extra_low_q};

  assign magic_bad = (header_count_q == 4'd0 && data_byte_i != MagicByte0) ||
                     (header_count_q == 4'd1 && data_byte_i != MagicByte1) ||
                     (header_count_q == 4'd2 && data_byte_i != MethodDeflate);

  always_comb begin
    header_count_d = header_count_q;
    extra_flag_d = extra_flag_q;
    name_flag_d = name_flag_q;
    extra_low_d = extra_low_q;
    skip_d = skip_q;
    next_phase = phase_q;
    done = 1'b0;
    name_valid = 1'b0;
    status = StatusNameDone;
    ef = extra_flag_q;
    nf = name_flag_q;
    unique case (phase_q)
      PhFixed: begin
        if (magic_bad) begin
          done = 1'b1;
          status = StatusBadMagic;
          next_phase = PhWait;
        end else begin
          if (header_count_q == 4'd3) begin
            ef = data_byte_i[FlagExtraBit];
            nf = data_byte_i[FlagNameBit];
          end
          extra_flag_d = ef;
          name_flag_d = nf;
          if (header_count_q >= FixedLen - 4'd1) begin
            header_count_d = FixedLen;
            if (!nf) begin
              done = 1'b1;
              status = StatusNoName;
              next_phase = PhWait;
            end else if (ef) begin
              next_phase = PhXlo;
            end else begin
              next_phase = PhName;
            end
          end else begin
            header_count_d = header_count_q + 4'd1;
          end
        end
      end
      PhXlo: begin
        extra_low_d = data_byte_i;
        next_phase = PhXhi;
      end
      PhXhi: begin
        skip_d = extra_len;
        next_phase = (extra_len == 16'd0) ? PhName : PhSkip;
      end
      PhSkip: begin
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) begin
          next_phase = PhName;
        end
      end
      PhName: begin
        if (data_byte_i == 8'd0) begin
          done = 1'b1;
          status = StatusNameDone;
          next_phase = PhWait;
        end else begin
          name_valid = 1'b1;
        end
      end
      default: begin
        next_phase = PhWait;
      end
    endcase

    if (end_of_file_i && !done && next_phase != PhWait) begin
      done = 1'b1;
      status = (next_phase == PhName) ? StatusNameTrunc : StatusHdrTrunc;
    end

    if (end_of_file_i) begin
      phase_d = PhFixed;
      header_count_d = 4'd0;
      extra_flag_d = 1'b0;
      name_flag_d = 1'b0;
      extra_low_d = 8'd0;
      skip_d = 16'd0;
    end else begin
      phase_d = done ? PhWait : next_phase;
    end
  end

  assign push_valid_o = accept & (done | name_valid);
  assign push_data_o.name_byte = name_valid ? data_byte_i : 8'd0;
  assign push_data_o.byte_valid = name_valid;
  assign push_data_o.done_res = done;
  assign push_data_o.status = done ? status : StatusNameDone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFixed;
      header_count_q <= 4'd0;
      extra_flag_q <= 1'b0;
      name_flag_q <= 1'b0;
      extra_low_q <= 8'd0;
      skip_q <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      header_count_q <= header_count_d;
      extra_flag_q <= extra_flag_d;
      name_flag_q <= name_flag_d;
      extra_low_q <= extra_low_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: src/gzhne_queue.sv
// Back end: a small result queue that holds classified results and drives the
// output channel from its head; depends on gzhne_pkg.
module gzhne_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  gzhne_pkg::result_t push_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gzhne_pkg::result_t out_data_o
);
  import gzhne_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  result_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign out_valid_o = (count_q != '0);
  assign out_data_o = mem_q[rd_ptr_q];
  assign do_push = push_valid_i & push_ready_o;
  assign do_pop = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// File: src/gzip_header_name_extractor.sv
// Each result is registered in the result queue and offered from its head.
// Throughput: one byte per cycle while the queue has room; state updates per byte.
// Input ready drops only while the result queue holds QueueDepth undelivered results.
// Reset clears the parser to the start of a fixed header and empties the queue.
// Top level of the gzip header name extractor; instantiates gzhne_front and
// gzhne_queue and depends on gzhne_pkg.
module gzip_header_name_extractor #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] name_byte_o,
  output logic       byte_valid_o,
  output logic       done_res_o,
  output logic [2:0] status_o
);
  import gzhne_pkg::*;

  logic    push_valid;
  logic    push_ready;
  result_t push_data;
  result_t out_data;

  gzhne_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data)
  );

  gzhne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data)
  );

  assign name_byte_o = out_data.name_byte;
  assign byte_valid_o = out_data.byte_valid;
  assign done_res_o = out_data.done_res;
  assign status_o = out_data.status;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result is pending");

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o || done_res_o))
    else $error("result carries neither a name byte nor done");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (status_o <= StatusNameTrunc))
    else $error("status code out of range");

  a_name_byte_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> (name_byte_o != 8'd0))
    else $error("name byte is the terminator");
`endif

endmodule

// File: tb/gzip_header_name_extractor_tb.sv
// Self-checking testbench for gzip_header_name_extractor.
// Streams gzip files through the valid/ready request channel, predicts every result
// in a local header parser and checks it; depends on gzhne_pkg and the RTL only.
module gzip_header_name_extractor_tb;
  import gzhne_pkg::*;

  typedef enum logic [2:0] {
    PhFixed,
    PhExtraLo,
    PhExtraHi,
    PhSkip,
    PhName,
    PhWait
  } parse_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       end_of_file_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] name_byte_o;
  logic       byte_valid_o;
  logic       done_res_o;
  logic [2:0] status_o;

  parse_phase_e parse_phase;
  int           hdr_count;
  logic         has_extra;
  logic         has_name;
  logic [7:0]   extra_lo;
  logic [15:0]  skip_left;

  result_t    pending_results[$];
  logic [7:0] file_buf[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;
  int err_cnt = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int name_chars = 0;
  int done_results = 0;

  gzip_header_name_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .name_byte_o  (name_byte_o),
    .byte_valid_o (byte_valid_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void rearm_parser();
    parse_phase = PhFixed;
    hdr_count = 0;
    has_extra = 1'b0;
    has_name = 1'b0;
    extra_lo = 8'h00;
    skip_left = 16'h0000;
  endfunction

  function automatic void add_file_byte(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endfunction

  function automatic void parse_header_byte(input logic [7:0] b, input logic eof);
    result_t res;
    parse_phase_e nxt;
    res = '0;
    nxt = parse_phase;
    case (parse_phase)
      PhFixed: begin
        if ((hdr_count == 0 && b != MagicByte0) || (hdr_count == 1 && b != MagicByte1) ||
            (hdr_count == 2 && b != MethodDeflate)) begin
          res.done_res = 1'b1;
          res.status = StatusBadMagic;
          nxt = PhWait;
        end else begin
          if (hdr_count == 3) begin
            has_extra = b[FlagExtraBit];
            has_name = b[FlagNameBit];
          end
          hdr_count++;
          if (hdr_count == int'(FixedLen)) begin
            if (!has_name) begin
              res.done_res = 1'b1;
              res.status = StatusNoName;
              nxt = PhWait;
            end else begin
              nxt = has_extra ? PhExtraLo : PhName;
            end
          end
        end
      end
      PhExtraLo: begin
        extra_lo = b;
        nxt = PhExtraHi;
      end
      PhExtraHi: begin
        skip_left = {b, extra_lo};
        nxt = (skip_left == 16'h0000) ? PhName : PhSkip;
      end
      PhSkip: begin
        skip_left--;
        if (skip_left == 16'h0000) nxt = PhName;
      end
      PhName: begin
        if (b == 8'h00) begin
          res.done_res = 1'b1;
          res.status = StatusNameDone;
          nxt = PhWait;
        end else begin
          res.byte_valid = 1'b1;
          res.name_byte = b;
        end
      end
      default: ;
    endcase
    if (eof && !res.done_res && nxt != PhWait) begin
      res.done_res = 1'b1;
      res.status = (nxt == PhName) ? StatusNameTrunc : StatusHdrTrunc;
    end
    if (eof) rearm_parser();
    else parse_phase = res.done_res ? PhWait : nxt;
    if (res.done_res || res.byte_valid) pending_results.insert(pending_results.size(), res);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_header_byte(b, eof);
    bytes_sent++;
    gap = 0;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++) begin
      send_byte(file_buf[i], i == file_buf.size() - 1);
    end
    file_buf.delete();
    files_sent++;
  endtask

  task automatic build_header(input logic [7:0] flags, input int xlen, input int name_len,
                              input int trail);
    file_buf.delete();
    add_file_byte(MagicByte0);
    add_file_byte(MagicByte1);
    add_file_byte(MethodDeflate);
    add_file_byte(flags);
    repeat (6) add_file_byte(8'($urandom_range(0, 255)));
    if (flags[FlagExtraBit]) begin
      add_file_byte(xlen[7:0]);
      add_file_byte(xlen[15:8]);
      repeat (xlen) add_file_byte(8'($urandom_range(0, 255)));
    end
    if (flags[FlagNameBit]) begin
      repeat (name_len) add_file_byte(8'($urandom_range(1, 255)));
      add_file_byte(8'h00);
    end
    repeat (trail) add_file_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic truncate_file(input int len);
    while (file_buf.size() > len) file_buf.delete(file_buf.size() - 1);
  endtask

  task automatic test_fixed_header_errors();
    build_header(8'h08, 0, 3, 2);
    file_buf[0] = 8'h00;
    send_file();
    build_header(8'h08, 0, 3, 0);
    file_buf[1] = 8'h8A;
    send_file();
    build_header(8'h08, 0, 3, 1);
    file_buf[2] = 8'hF7;
    send_file();
    add_file_byte(8'hFF);
    send_file();
  endtask

  task automatic test_flag_handling();
    build_header(8'h00, 0, 0, 3);
    send_file();
    build_header(8'h04, 2, 0, 4);
    send_file();
    build_header(8'hF7, 5, 0, 1);
    send_file();
    build_header(8'h00, 0, 0, 0);
    send_file();
    build_header(8'h08, 0, 5, 2);
    send_file();
    build_header(8'hFF, 0, 4, 1);
    send_file();
    build_header(8'h0C, 3, 1, 2);
    send_file();
    build_header(8'h08, 0, 0, 2);
    send_file();
    build_header(8'h08, 0, 2, 1);
    file_buf[10] = 8'h01;
    file_buf[11] = 8'hFF;
    send_file();
    build_header(8'h08, 0, 3, 0);
    send_file();
  endtask

  task automatic test_truncation();
    build_header(8'h08, 0, 4, 0);
    truncate_file(1);
    send_file();
    build_header(8'h08, 0, 4, 0);
    truncate_file(3);
    send_file();
    build_header(8'h08, 0, 4, 0);
    truncate_file(5);
    send_file();
    build_header(8'h0C, 4, 2, 0);
    truncate_file(11);
    send_file();
    build_header(8'h0C, 4, 2, 0);
    truncate_file(12);
    send_file();
    build_header(8'h0C, 4, 2, 0);
    truncate_file(14);
    send_file();
    build_header(8'h0C, 4, 2, 0);
    truncate_file(16);
    send_file();
    build_header(8'h08, 0, 4, 0);
    truncate_file(10);
    send_file();
    build_header(8'h0C, 0, 3, 0);
    truncate_file(12);
    send_file();
    build_header(8'h08, 0, 4, 0);
    truncate_file(12);
    send_file();
  endtask

  task automatic test_long_extra_field();
    in_idle_pct = 0;
    out_stall_pct = 0;
    build_header(8'h0C, 16'h0123, 2, 1);
    send_file();
  endtask

  task automatic test_random_streams(input int n_bytes);
    int stop_at;
    int kind;
    int xlen;
    int idx;
    logic [7:0] flags;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if (files_sent % 16 == 0) begin
        case ($urandom_range(0, 3))
          0: in_idle_pct = 0;
          1: in_idle_pct = 15;
          2: in_idle_pct = 40;
          default: in_idle_pct = 70;
        endcase
        case ($urandom_range(0, 3))
          0: out_stall_pct = 0;
          1: out_stall_pct = 20;
          2: out_stall_pct = 45;
          default: out_stall_pct = 70;
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 95) begin
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) flags[FlagNameBit] = 1'b1;
        xlen = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 64) : $urandom_range(0, 6);
        build_header(flags, xlen, $urandom_range(0, 16), $urandom_range(0, 4));
        if (kind >= 70 && kind < 85) begin
          truncate_file($urandom_range(1, file_buf.size()));
        end else if (kind >= 85) begin
          idx = $urandom_range(0, 2);
          file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
        end
      end else begin
        file_buf.delete();
        repeat ($urandom_range(1, 24)) add_file_byte(8'($urandom_range(0, 255)));
      end
      send_file();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("Unexpected result: name_byte %0h byte_valid %0b done_res %0b status %0d",
               name_byte_o, byte_valid_o, done_res_o, status_o);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.byte_valid) name_chars++;
        if (exp_r.done_res) done_results++;
        if (name_byte_o !== exp_r.name_byte) begin
          $error("name_byte: expected %0h, actual %0h", exp_r.name_byte, name_byte_o);
          err_cnt++;
        end
        if (byte_valid_o !== exp_r.byte_valid) begin
          $error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, byte_valid_o);
          err_cnt++;
        end
        if (done_res_o !== exp_r.done_res) begin
          $error("done_res: expected %0b, actual %0b", exp_r.done_res, done_res_o);
          err_cnt++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(8 * 2_000_000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    end_of_file_i = 1'b0;
    rearm_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fixed_header_errors();
    out_stall_pct = 30;
    in_idle_pct = 30;
    test_flag_handling();
    test_truncation();
    test_long_extra_field();
    test_random_streams(1200);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d files, including one long extra field.",
             bytes_sent, files_sent);
    $display("Checked %0d name characters and %0d header completions.",
             name_chars, done_results);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
